// ===== src/assert_macros.svh =====
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/jetp_pkg.sv =====
`timescale 1ns / 1ps

package jetp_pkg;

	localparam int COORD_BITS = 11;
	localparam int FRAC_BITS  = 24;

	localparam int Z_W        = 32;
	localparam int STEP_W     = 31;
	localparam int MAXIT_W    = 16;
	localparam int CNT_W      = MAXIT_W + 1;
	localparam int CFG_W      = 32;
	localparam int CFG_ADDR_W = 3;

	localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((CNT_W + 7) / 8) * 8;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ORIGIN_RE = 3'd0,
		REG_ORIGIN_IM = 3'd1,
		REG_STEP      = 3'd2,
		REG_JULIA_RE  = 3'd3,
		REG_JULIA_IM  = 3'd4,
		REG_MAX_ITER  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_MUL,
		ST_SUM,
		ST_UPD,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;         // latch pixel, scale by step, clear count
		logic init;         // form saturated start point
		logic mul;          // register the two squares and the cross product
		logic sum;          // combine and shift products
		logic upd;          // add c, saturate, write z
		logic inc;          // advance iteration count
		logic capture;      // load the result register
		logic inside_flag;  // inside flag for the captured result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic escape;   // last update overflowed or |z|^2 > 4
		logic last;     // count has reached max_iter
	} dp_sts_t;

endpackage

// ===== src/jetp_ctrl.sv =====
`timescale 1ns / 1ps

module jetp_ctrl import jetp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic   first_q, first_d;
	logic   inside_q, inside_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			first_q     <= first_d;
			inside_q    <= inside_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		first_d  = first_q;
		inside_d = inside_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				cmd.init = 1'b1;
				first_d  = 1'b1;
				inside_d = 1'b0;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				// the start point itself is never tested
				if (first_q) begin
					cmd.sum = 1'b1;
					first_d = 1'b0;
					state_d = ST_UPD;
				end else if (sts.escape) begin
					state_d = ST_DONE;
				end else if (sts.last) begin
					cmd.inc  = 1'b1;
					inside_d = 1'b1;
					state_d  = ST_DONE;
				end else begin
					cmd.inc = 1'b1;
					cmd.sum = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_MUL;
			end
			ST_DONE: begin
				cmd.inside_flag = inside_q;
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.capture = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.capture) begin
			out_valid_d = 1'b1;
		end else begin
			out_valid_d = out_valid_q && !out_ready;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/jetp_dp.sv =====
`timescale 1ns / 1ps

module jetp_dp import jetp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output logic [CNT_W-1:0]      iter_count,
	output logic                  inside_res
);

	localparam int PX_W    = COORD_BITS + STEP_W;
	localparam int START_W = PX_W + 2;
	localparam int PROD_W  = 2 * Z_W;
	localparam int RE_W    = PROD_W - FRAC_BITS;
	localparam int IM_W    = PROD_W - FRAC_BITS + 1;
	localparam int UPD_W   = IM_W + 1;
	localparam int SAT_W   = (START_W > UPD_W) ? START_W : UPD_W;
	localparam logic [PROD_W-1:0] MAG_LIMIT = 64'd4 << (2 * FRAC_BITS);

	// returns {overflow, saturated value}
	function automatic logic [Z_W:0] sat_z(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-Z_W:0] top;
		top = v[SAT_W-1:Z_W-1];
		if ((&top) || !(|top)) begin
			return {1'b0, v[Z_W-1:0]};
		end else if (v[SAT_W-1]) begin
			return {1'b1, 1'b1, {(Z_W-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(Z_W-1){1'b1}}};
		end
	endfunction

	logic signed [Z_W-1:0]     origin_re_q, origin_im_q, julia_re_q, julia_im_q;
	logic        [STEP_W-1:0]  step_q;
	logic        [MAXIT_W-1:0] max_iter_q;
	logic        [CNT_W-1:0]   cnt_q;

	logic        [PX_W-1:0]    prodx_q, prody_q;
	logic signed [Z_W-1:0]     zr_q, zi_q;
	logic signed [PROD_W-1:0]  rr_q, ii_q, ri_q;
	logic signed [RE_W-1:0]    re_sh_q;
	logic signed [IM_W-1:0]    im_sh_q;
	logic                      ovf_q;
	logic        [CNT_W-1:0]   res_cnt_q;
	logic                      res_inside_q;

	logic signed [START_W-1:0] start_re, start_im;
	logic signed [UPD_W-1:0]   next_re, next_im;
	logic        [Z_W:0]       sat_sre, sat_sim, sat_nre, sat_nim;
	logic signed [PROD_W-1:0]  diff;
	logic        [PROD_W-1:0]  mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= -32'sd33554432;
			origin_im_q <= 32'sd33554432;
			step_q      <= 31'd65536;
			julia_re_q  <= '0;
			julia_im_q  <= '0;
			max_iter_q  <= 16'd100;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_ORIGIN_RE: origin_re_q <= cfg_data;
					REG_ORIGIN_IM: origin_im_q <= cfg_data;
					REG_STEP:      step_q      <= cfg_data[STEP_W-1:0];
					REG_JULIA_RE:  julia_re_q  <= cfg_data;
					REG_JULIA_IM:  julia_im_q  <= cfg_data;
					REG_MAX_ITER:  max_iter_q  <= cfg_data[MAXIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.upd) begin
				ovf_q <= sat_nre[Z_W] | sat_nim[Z_W];
			end
		end
	end

	assign start_re = START_W'(origin_re_q) + signed'({2'b00, prodx_q});
	assign start_im = START_W'(origin_im_q) - signed'({2'b00, prody_q});
	assign sat_sre  = sat_z(SAT_W'(start_re));
	assign sat_sim  = sat_z(SAT_W'(start_im));

	assign diff = rr_q - ii_q;
	assign mag  = $unsigned(rr_q) + $unsigned(ii_q);

	assign next_re = UPD_W'(re_sh_q) + UPD_W'(julia_re_q);
	assign next_im = UPD_W'(im_sh_q) + UPD_W'(julia_im_q);
	assign sat_nre = sat_z(SAT_W'(next_re));
	assign sat_nim = sat_z(SAT_W'(next_im));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prodx_q <= PX_W'(pixel_x) * PX_W'(step_q);
			prody_q <= PX_W'(pixel_y) * PX_W'(step_q);
		end
		if (cmd.init) begin
			zr_q <= sat_sre[Z_W-1:0];
			zi_q <= sat_sim[Z_W-1:0];
		end else if (cmd.upd) begin
			zr_q <= sat_nre[Z_W-1:0];
			zi_q <= sat_nim[Z_W-1:0];
		end
		if (cmd.mul) begin
			rr_q <= PROD_W'(zr_q) * PROD_W'(zr_q);
			ii_q <= PROD_W'(zi_q) * PROD_W'(zi_q);
			ri_q <= PROD_W'(zr_q) * PROD_W'(zi_q);
		end
		if (cmd.sum) begin
			re_sh_q <= RE_W'(diff >>> FRAC_BITS);
			im_sh_q <= IM_W'(ri_q >>> (FRAC_BITS - 1));
		end
		if (cmd.capture) begin
			res_cnt_q    <= cnt_q;
			res_inside_q <= cmd.inside_flag;
		end
	end

	assign sts.escape = ovf_q || (mag > MAG_LIMIT);
	assign sts.last   = (cnt_q == CNT_W'(max_iter_q));

	assign iter_count = res_cnt_q;
	assign inside_res = res_inside_q;

endmodule

// ===== src/julia_escape_time_pixel_top.sv =====
`timescale 1ns / 1ps

// Julia-set escape-time engine for one pixel per input word. The pixel maps to
// z = (origin_re + x*step) + i*(origin_im - y*step) in signed Q8.24, then
// z = z^2 + c iterates until an update saturates, |z|^2 > 4 or max_iter+1
// updates are done; the result word gives the escape index and, in tuser,
// the inside flag. One pixel is in flight at a time: a pixel with U updates
// of z (iter_count+1 on escape, max_iter+1 when inside) runs through the
// start point, U rounds of the loop of products, shift-and-combine and
// saturating update, and a done state that waits for a free result register.
// The result register lets the next pixel start while the previous result
// waits. Write configuration only while no pixel is in flight.
module julia_escape_time_pixel_top import jetp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pixel_x, pixel_y, zero pad
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // iter_count, zero pad
	output logic                   m_axis_tuser    // inside_res
);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [CNT_W-1:0] iter_count;

	jetp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	jetp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.pixel_x    (s_axis_tdata[COORD_BITS-1:0]),
		.pixel_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.cmd        (cmd),
		.sts        (sts),
		.iter_count (iter_count),
		.inside_res (m_axis_tuser)
	);

	assign m_axis_tdata = OUT_TDATA_W'(iter_count);

endmodule

// ===== src/jetp_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jetp_chk import jetp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// one pixel in flight: no new word right after an accept
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !s_axis_tready)

	// an accept is never followed straight away by a new result
	`ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_acc, !$rose(m_axis_tvalid))

	// an inside point always made at least one update
	`ASSERT_IMPL(a_inside_count, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata[CNT_W-1:0] != '0)

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind julia_escape_time_pixel_top jetp_chk u_jetp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_julia_escape_time_pixel_top.sv =====
`timescale 1ns / 1ps

module tb_julia_escape_time_pixel_top;
	import jetp_pkg::*;

	localparam int FIX_ONE = 1 << FRAC_BITS;
	localparam int QUIET_LIMIT = 600000;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_ITEMS = 90;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
	localparam longint Z_MAX = 64'sd2147483647;
	localparam longint Z_MIN = -64'sd2147483648;
	localparam longint unsigned ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

	typedef struct packed {
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic                  hold;   // wait until every result is back
	} pixel_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             inside_flag;
	} esc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // pixel_x, pixel_y, zero pad
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // iter_count, zero pad
	logic m_axis_tuser;                         // inside_res

	// shadow copy of the register file
	int org_re = -2 * FIX_ONE;
	int org_im = 2 * FIX_ONE;
	int unsigned pix_step = 65536;
	int jc_re = 0;
	int jc_im = 0;
	int unsigned iter_limit = 100;

	pixel_item_t pixel_q[$];
	esc_result_t escape_q[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	julia_escape_time_pixel_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clamp_z(input longint v);
		if (v > Z_MAX)
			return Z_MAX;
		if (v < Z_MIN)
			return Z_MIN;
		return v;
	endfunction

	function automatic esc_result_t julia_escape(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py);
		longint zr, zi, rr, ii, ri, nr, ni;
		longint unsigned mag;
		int unsigned n;
		esc_result_t r;
		zr = clamp_z(longint'(org_re) + longint'(px) * longint'(pix_step));
		zi = clamp_z(longint'(org_im) - longint'(py) * longint'(pix_step));
		n = 0;
		while (n <= iter_limit) begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			nr = ((rr - ii) >>> FRAC_BITS) + jc_re;
			ni = (ri >>> (FRAC_BITS - 1)) + jc_im;
			zr = clamp_z(nr);
			zi = clamp_z(ni);
			mag = $unsigned(zr * zr) + $unsigned(zi * zi);
			// a saturated update always counts as escape
			if (zr != nr || zi != ni || mag > ESC_LIMIT)
				break;
			n++;
		end
		r.count = n[CNT_W-1:0];
		r.inside_flag = (n == iter_limit + 1);
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_ORIGIN_RE: org_re = val;
			REG_ORIGIN_IM: org_im = val;
			REG_STEP:      pix_step = {1'b0, val[STEP_W-1:0]};
			REG_JULIA_RE:  jc_re = val;
			REG_JULIA_IM:  jc_im = val;
			REG_MAX_ITER:  iter_limit = val[MAXIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_pixel(input int x, input int y, input bit hold);
		pixel_item_t it;
		it.px = x[COORD_BITS-1:0];
		it.py = y[COORD_BITS-1:0];
		it.hold = hold;
		pixel_q.push_back(it);
	endtask

	// sample at the falling edge so the handshake state is settled
	task automatic drain();
		do
			@(negedge clk);
		while (pixel_q.size() != 0 || s_axis_tvalid || escape_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_item_t it;
		logic [IN_TDATA_W-1:0] word;
		bit go;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				escape_q.push_back(julia_escape(s_axis_tdata[COORD_BITS-1:0],
					s_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
			if (!s_axis_tvalid || s_axis_tready) begin
				go = pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
				if (go && pixel_q[0].hold && escape_q.size() != 0)
					go = 1'b0;
				if (go) begin
					it = pixel_q.pop_front();
					word = '0;
					word[COORD_BITS-1:0] = it.px;
					word[2*COORD_BITS-1:COORD_BITS] = it.py;
					s_axis_tdata <= word;
				end
				s_axis_tvalid <= go;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		esc_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (escape_q.size() == 0) begin
					$error("result word with nothing pending: iter_count %0d",
						m_axis_tdata[CNT_W-1:0]);
					mismatch_count++;
				end else begin
					want = escape_q.pop_front();
					if (m_axis_tdata[CNT_W-1:0] !== want.count) begin
						$error("iter_count: expected %0d, actual %0d", want.count,
							m_axis_tdata[CNT_W-1:0]);
						mismatch_count++;
					end
					if (m_axis_tuser !== want.inside_flag) begin
						$error("inside_res: expected %0d, actual %0d", want.inside_flag,
							m_axis_tuser);
						mismatch_count++;
					end
				end
			end
			m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int ph, k, span, zsh, cre, cim, step_val, x, y;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: window [-2,6] x [-6,2] at 1/256, c = 0
		add_pixel(0, 0, 0);
		add_pixel(2047, 2047, 0);
		add_pixel(512, 512, 0);
		add_pixel(768, 512, 0);
		add_pixel(512, 768, 0);
		add_pixel(1023, 512, 0);
		add_pixel(640, 512, 1);
		drain();

		// single update when the limit is zero
		write_reg(REG_JULIA_RE, -13421773);
		write_reg(REG_JULIA_IM, 2617246);
		write_reg(REG_MAX_ITER, 0);
		add_pixel(512, 512, 0);
		add_pixel(0, 0, 0);
		add_pixel(2047, 0, 0);
		drain();
		write_reg(REG_MAX_ITER, 255);
		add_pixel(600, 500, 0);
		add_pixel(450, 530, 0);
		drain();

		// start point at or past the extremes, first update overflows
		write_reg(REG_ORIGIN_RE, 32'h7FFFFFFF);
		write_reg(REG_ORIGIN_IM, 32'h80000000);
		write_reg(REG_STEP, 32'h7FFFFFFF);
		write_reg(REG_JULIA_RE, 32'h7FFFFFFF);
		write_reg(REG_JULIA_IM, 32'h80000000);
		write_reg(REG_MAX_ITER, 3);
		add_pixel(2047, 2047, 0);
		add_pixel(0, 0, 0);
		drain();

		// c at the opposite extremes from a zero start
		write_reg(REG_ORIGIN_RE, 0);
		write_reg(REG_ORIGIN_IM, 0);
		write_reg(REG_STEP, 0);
		write_reg(REG_JULIA_RE, 32'h80000000);
		write_reg(REG_JULIA_IM, 32'h7FFFFFFF);
		add_pixel(1, 1, 0);
		drain();

		// zero step: every pixel lands on the same contracting point
		write_reg(REG_ORIGIN_RE, -FIX_ONE / 2);
		write_reg(REG_ORIGIN_IM, FIX_ONE / 2);
		write_reg(REG_JULIA_RE, 0);
		write_reg(REG_JULIA_IM, 0);
		add_pixel(2047, 0, 0);
		add_pixel(0, 2047, 0);
		drain();

		// writes past the register list must change nothing
		write_reg(REG_SPARE_6, $urandom());
		write_reg(REG_SPARE_7, $urandom());
		add_pixel(3, 3, 0);
		drain();

		// longest pixel: z stays at zero through every update
		write_reg(REG_ORIGIN_RE, 0);
		write_reg(REG_ORIGIN_IM, 0);
		write_reg(REG_MAX_ITER, 16'hFFFF);
		add_pixel(7, 9, 0);
		drain();
		write_reg(REG_ORIGIN_RE, 5 * FIX_ONE / 2);
		add_pixel(0, 0, 0);
		drain();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			span = 2047;
			if ($urandom_range(9) < 2) begin
				// noise settings; keep the limit low so runs stay short
				write_reg(REG_ORIGIN_RE, $urandom());
				write_reg(REG_ORIGIN_IM, $urandom());
				write_reg(REG_STEP, $urandom());
				write_reg(REG_JULIA_RE, $urandom());
				write_reg(REG_JULIA_IM, $urandom());
				write_reg(REG_MAX_ITER, ($urandom() & 32'hFFFF0000) | $urandom_range(63));
			end else begin
				case ($urandom_range(6))
					0: begin cre = -13421773; cim = 2617246;   end
					1: begin cre = 4781507;   cim = 167772;    end
					2: begin cre = -6710886;  cim = 10066330;  end
					3: begin cre = -11773579; cim = -6445806;  end
					4: begin cre = 5955912;   cim = 5955912;   end
					5: begin cre = -14008975; cim = -3893992;  end
					default: begin cre = 0;   cim = 0;         end
				endcase
				cre += int'($urandom_range(65535)) - 32768;
				cim += int'($urandom_range(65535)) - 32768;
				span = $urandom_range(16, 2047);
				zsh = $urandom_range(3);
				step_val = ((4 * FIX_ONE) >> zsh) / span;
				write_reg(REG_ORIGIN_RE, -((2 * FIX_ONE) >> zsh) +
					int'($urandom_range(FIX_ONE / 2)) - FIX_ONE / 4);
				write_reg(REG_ORIGIN_IM, ((2 * FIX_ONE) >> zsh) +
					int'($urandom_range(FIX_ONE / 2)) - FIX_ONE / 4);
				write_reg(REG_STEP, step_val);
				write_reg(REG_JULIA_RE, cre);
				write_reg(REG_JULIA_IM, cim);
				write_reg(REG_MAX_ITER, $urandom_range(80));
			end
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(99) < 15) begin
					x = $urandom_range(2047);
					y = $urandom_range(2047);
				end else begin
					x = $urandom_range(span);
					y = $urandom_range(span);
				end
				add_pixel(x, y, $urandom_range(49) == 0);
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
